// File: hdl/pcc_pkg.sv
// Package for the pixel copy command decoder: beat types, codes and the
// command-byte decode function. No dependencies.
`timescale 1ns / 1ps

package pcc_pkg;

  // Fixed field widths of the beats
  localparam int TOKEN_W = 16;
  localparam int PIX_W   = 16;
  localparam int POS_W   = 14;
  localparam int TOTAL_W = 15;
  localparam int LEN_W   = 8;   // pixels per token, up to 128
  localparam int PER_W   = 4;   // pattern period, 2..9
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = TOTAL_W;

  // Parameter defaults
  localparam int HISTORY_DEPTH_DEF = 128;
  localparam int MAX_PIXELS_DEF    = 16384;
  localparam int PIXEL_BITS_DEF    = 16;

  localparam logic [TOTAL_W-1:0] PIXEL_TOTAL_RST = TOTAL_W'(16384);

  typedef enum logic [1:0] {
    OP_LITERAL = 2'd0,
    OP_COMMAND = 2'd1,
    OP_START   = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COMMAND_SET = 1'd0,
    CFG_PIXEL_TOTAL = 1'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_LIT,
    MODE_PAT,
    MODE_MIR,
    MODE_RUN
  } mode_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  typedef struct packed {
    logic [1:0]         op;
    logic [TOKEN_W-1:0] token_value;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_first;
    logic [PIX_W-1:0] pixel_second;
    logic             second_valid;
    logic [POS_W-1:0] position;
    logic             run_last;
    logic             image_done;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch a pixel-producing token
    logic clear;      // start of a new image
    logic mark_full;  // token dropped on a full image
    logic run;        // expansion in progress
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic finished;
    logic busy;
  } stat_t;

  typedef struct packed {
    mode_e            mode;
    logic [PER_W-1:0] per;
    logic [LEN_W-1:0] len;
  } dec_t;

  // Field layout of a command byte under either command set
  function automatic dec_t decode_cmd(logic [7:0] b, logic set7);
    dec_t       d;
    logic [1:0] sel;
    logic [2:0] p;
    logic [2:0] r;
    logic [5:0] m;
    logic [6:0] rl;
    if (!set7) begin
      sel = b[7:6];
      p   = b[5:3];
      r   = b[2:0];
      m   = b[5:0];
      rl  = b[6:0];
    end else begin
      sel = b[6:5];
      p   = b[4:2];
      r   = {1'b0, b[1:0]};
      m   = {1'b0, b[4:0]};
      rl  = {1'b0, b[5:0]};
    end
    d.per = PER_W'(p) + PER_W'(2);
    case (sel)
      2'b00: begin
        d.mode = MODE_PAT;
        d.len  = LEN_W'(d.per) * (LEN_W'(r) + LEN_W'(1));
      end
      2'b01: begin
        d.mode = MODE_MIR;
        d.len  = LEN_W'(m) + LEN_W'(2);
      end
      default: begin
        d.mode = MODE_RUN;
        d.len  = LEN_W'(rl) + LEN_W'(1);
      end
    endcase
    return d;
  endfunction

endpackage

// File: hdl/pcc_ctrl.sv
// Token controller of the pixel copy command decoder: takes input beats
// and sequences one token's expansion. Depends on pcc_pkg.
`timescale 1ns / 1ps

module pcc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        op_i,
  input  pcc_pkg::stat_t    st_i,
  output logic              in_stall_o,
  output pcc_pkg::cmd_t     cmd_o
);

  pcc_pkg::state_e state_q, state_d;
  logic accept;
  logic pix_op;
  logic produce;

  assign accept  = in_valid_i && (state_q == pcc_pkg::ST_IDLE);
  assign pix_op  = op_i inside {pcc_pkg::OP_LITERAL, pcc_pkg::OP_COMMAND};
  assign produce = pix_op && !st_i.full && !st_i.finished;

  always_comb begin
    state_d = state_q;
    case (state_q)
      pcc_pkg::ST_IDLE: begin
        if (accept && produce) state_d = pcc_pkg::ST_RUN;
      end
      pcc_pkg::ST_RUN: begin
        if (!st_i.busy) state_d = pcc_pkg::ST_IDLE;
      end
      default: state_d = pcc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o      = (state_q != pcc_pkg::ST_IDLE);
    cmd_o.load      = accept && produce;
    cmd_o.clear     = accept && (op_i == pcc_pkg::OP_START);
    cmd_o.mark_full = accept && pix_op && st_i.full;
    cmd_o.run       = (state_q == pcc_pkg::ST_RUN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hdl/pcc_datapath.sv
// Datapath of the pixel copy command decoder: history ring, look-back
// address generation, pixel pairing and the output register. Depends on pcc_pkg.
`timescale 1ns / 1ps

module pcc_datapath #(
  parameter int HISTORY_DEPTH = pcc_pkg::HISTORY_DEPTH_DEF,
  parameter int MAX_PIXELS    = pcc_pkg::MAX_PIXELS_DEF,
  parameter int PIXEL_BITS    = pcc_pkg::PIXEL_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pcc_pkg::cmd_t                cmd_i,
  output pcc_pkg::stat_t               st_o,
  input  pcc_pkg::in_t                 in_i,
  input  logic                         command_set_i,
  input  logic [pcc_pkg::TOTAL_W-1:0]  pixel_total_i,
  output pcc_pkg::out_t                out_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i
);

  // Ring rounded up to a power of two; look-back never exceeds 65 pixels
  localparam int AW   = $clog2(HISTORY_DEPTH);
  localparam int RING = 1 << AW;
  localparam int WPW  = $clog2(MAX_PIXELS + 1);
  localparam int CW   = (WPW > pcc_pkg::TOTAL_W) ? WPW : pcc_pkg::TOTAL_W;
  localparam int LW   = pcc_pkg::LEN_W;
  localparam int PW   = pcc_pkg::PER_W;

  logic [PIXEL_BITS-1:0] ring_mem [RING];

  // image state
  logic [WPW-1:0] wpos_q;
  logic           fin_q;

  // token being expanded
  logic [WPW-1:0]        base_q;
  pcc_pkg::mode_e        mode_q;
  logic [PW-1:0]         per_q;
  logic [PW-1:0]         j_q;
  logic [LW-1:0]         k_q;
  logic [LW-1:0]         n_q;
  logic [PIXEL_BITS-1:0] lit_q;
  logic                  done_q;

  // read stage
  logic                  s1_vld_q;
  logic [LW-1:0]         s1_k_q;
  logic                  s1_last_q;
  logic [PIXEL_BITS-1:0] rd_q;
  logic                  zero_q;

  // pairing and output
  logic [PIXEL_BITS-1:0] half_q;
  pcc_pkg::out_t         out_q;
  logic                  out_vld_q;

  logic [CW-1:0]         tot_ext;
  logic [CW-1:0]         max_ext;
  logic [WPW-1:0]        limit;
  logic [WPW-1:0]        room;
  pcc_pkg::dec_t         dec;
  logic                  fits;
  logic [LW-1:0]         n_new;
  logic [LW-1:0]         lag;
  logic [AW-1:0]         raddr;
  logic [AW-1:0]         waddr;
  logic                  zero_cur;
  logic                  last_cur;
  logic                  out_free;
  logic                  pushing;
  logic                  s1_adv;
  logic                  issue;
  logic [PIXEL_BITS-1:0] pix;
  pcc_pkg::out_t         out_d;

  // decode of the token at the input
  assign tot_ext = CW'(pixel_total_i);
  assign max_ext = CW'(MAX_PIXELS);
  assign limit   = WPW'((tot_ext > max_ext) ? max_ext : tot_ext);
  assign room    = limit - wpos_q;

  always_comb begin
    if (in_i.op == pcc_pkg::OP_LITERAL) begin
      dec.mode = pcc_pkg::MODE_LIT;
      dec.per  = '0;
      dec.len  = LW'(1);
    end else begin
      dec = pcc_pkg::decode_cmd(in_i.token_value[7:0], command_set_i);
    end
  end

  assign fits  = WPW'(dec.len) < room;
  assign n_new = fits ? dec.len : LW'(room);

  assign st_o.full     = (wpos_q >= limit);
  assign st_o.finished = fin_q;
  assign st_o.busy     = (k_q != n_q) || s1_vld_q;

  // look-back distance of the pixel being issued
  always_comb begin
    case (mode_q)
      pcc_pkg::MODE_PAT: lag = LW'(per_q - j_q);
      pcc_pkg::MODE_MIR: lag = k_q + LW'(1);
      default:           lag = LW'(1);
    endcase
  end

  assign raddr    = AW'(base_q - WPW'(lag));
  assign zero_cur = WPW'(lag) > base_q;   // before image start
  assign last_cur = (k_q == (n_q - LW'(1)));

  // A read is issued no earlier than the write of the previous pixel, so a
  // same-address collision in a long mirror returns the old ring contents.
  assign out_free = !out_vld_q || !out_stall_i;
  assign pushing  = s1_k_q[0] || s1_last_q;
  assign s1_adv   = s1_vld_q && (!pushing || out_free);
  assign issue    = cmd_i.run && (k_q != n_q) && (!s1_vld_q || s1_adv);

  assign pix   = (mode_q == pcc_pkg::MODE_LIT) ? lit_q : (zero_q ? '0 : rd_q);
  assign waddr = AW'(base_q + WPW'(s1_k_q));

  always_comb begin
    if (s1_k_q[0]) begin
      out_d.pixel_first  = pcc_pkg::PIX_W'(half_q);
      out_d.pixel_second = pcc_pkg::PIX_W'(pix);
      out_d.second_valid = 1'b1;
    end else begin
      out_d.pixel_first  = pcc_pkg::PIX_W'(pix);
      out_d.pixel_second = '0;
      out_d.second_valid = 1'b0;
    end
    out_d.position   = pcc_pkg::POS_W'(base_q + WPW'({s1_k_q[LW-1:1], 1'b0}));
    out_d.run_last   = s1_last_q;
    out_d.image_done = s1_last_q && done_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q    <= '0;
      fin_q     <= 1'b0;
      k_q       <= '0;
      n_q       <= '0;
      j_q       <= '0;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        wpos_q <= '0;
        fin_q  <= 1'b0;
      end else if (cmd_i.mark_full) begin
        fin_q <= 1'b1;
      end else if (cmd_i.load) begin
        wpos_q <= wpos_q + WPW'(n_new);
        fin_q  <= !fits;
      end

      if (cmd_i.load) begin
        k_q <= '0;
        n_q <= n_new;
        j_q <= '0;
      end else if (issue) begin
        k_q <= k_q + LW'(1);
        j_q <= (j_q == (per_q - PW'(1))) ? '0 : j_q + PW'(1);
      end

      if (issue) begin
        s1_vld_q <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end

      if (s1_adv && pushing) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      base_q <= wpos_q;
      mode_q <= dec.mode;
      per_q  <= dec.per;
      lit_q  <= in_i.token_value[PIXEL_BITS-1:0];
      done_q <= !fits;
    end
    if (issue) begin
      rd_q      <= ring_mem[raddr];
      zero_q    <= zero_cur;
      s1_k_q    <= k_q;
      s1_last_q <= last_cur;
    end
    if (s1_adv && !s1_k_q[0]) begin
      half_q <= pix;
    end
    if (s1_adv && pushing) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      ring_mem[waddr] <= pix;
    end
  end

  assign out_o       = out_q;
  assign out_valid_o = out_vld_q;

endmodule

// File: hdl/pixel_copy_command_decoder.sv
// Top level of the pixel copy command decoder: configuration registers,
// controller and datapath. Depends on pcc_pkg, pcc_ctrl, pcc_datapath.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+-----------------------------
//   in       | in        | in_valid_i/in_stall_o | pcc_pkg::in_t (op, token)
//   out      | out       | out_valid_o/out_stall_i | pcc_pkg::out_t (pixel pair)
//   cfg      | in        | cfg_valid_i/cfg_ready_o | index + 15-bit data
//
// A token expands at one pixel per cycle through the ring's single read port
// while the output is not stalled; a token holds the input until its last pixel
// has left the read stage. Start-new-image and dropped tokens leave the input open.
// Output beats carry up to two pixels and sit in a register, so a stalled
// output pauses the expansion without loss. Reset needs no clearing pass:
// reads before the image start are forced to zero.
`timescale 1ns / 1ps

module pixel_copy_command_decoder #(
  parameter int HISTORY_DEPTH = pcc_pkg::HISTORY_DEPTH_DEF,
  parameter int MAX_PIXELS    = pcc_pkg::MAX_PIXELS_DEF,
  parameter int PIXEL_BITS    = pcc_pkg::PIXEL_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  pcc_pkg::in_t                    in_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output pcc_pkg::out_t                   out_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pcc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pcc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  logic                         cmd_set_q;
  logic [pcc_pkg::TOTAL_W-1:0]  total_q;
  pcc_pkg::cmd_t                cmd;
  pcc_pkg::stat_t               st;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_set_q <= 1'b0;
      total_q   <= pcc_pkg::PIXEL_TOTAL_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pcc_pkg::CFG_COMMAND_SET: cmd_set_q <= cfg_data_i[0];
        pcc_pkg::CFG_PIXEL_TOTAL: total_q   <= cfg_data_i[pcc_pkg::TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  pcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (in_i.op),
    .st_i       (st),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  pcc_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .MAX_PIXELS    (MAX_PIXELS),
    .PIXEL_BITS    (PIXEL_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .st_o          (st),
    .in_i          (in_i),
    .command_set_i (cmd_set_q),
    .pixel_total_i (total_q),
    .out_o         (out_o),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i)
  );

  // input is open only with no expansion in flight
  a_idle_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !st.busy)
    else $error("input open while expansion in flight");

  a_load_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> in_stall_o)
    else $error("token loaded without closing the input");

  a_done_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.image_done |-> out_o.run_last)
    else $error("image_done on a beat that is not the token's last");

endmodule

// File: dv/pcc_pixel_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the pixel copy command decoder: watches the token, pixel and
// register channels, predicts every pixel-pair beat and compares. Uses pcc_pkg.

module pcc_pixel_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  pcc_pkg::in_t                   in_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  pcc_pkg::out_t                  out_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [pcc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pcc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             pending_o,
  output int                             fail_count_o
);
  import pcc_pkg::*;

  localparam int RING_DEPTH = HISTORY_DEPTH_DEF;
  localparam int PIXEL_CAP  = MAX_PIXELS_DEF;
  localparam int BURST_CAP  = 128;
  localparam logic [1:0] SEL_PATTERN = 2'b00;
  localparam logic [1:0] SEL_MIRROR  = 2'b01;

  logic [PIX_W-1:0]   ring [RING_DEPTH];
  int unsigned        wr_pos;
  logic               img_finished;
  logic               set7;
  logic [TOTAL_W-1:0] total_cfg;
  out_t               expected_pairs [$];
  int                 mismatch_count = 0;

  assign fail_count_o = mismatch_count;

  function automatic string beat_text(out_t b);
    return $sformatf("first=%h second=%h pair=%b pos=%0d last=%b done=%b",
                     b.pixel_first, b.pixel_second, b.second_valid, b.position,
                     b.run_last, b.image_done);
  endfunction

  function automatic void note_failure(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("[%0t] %s", $time, msg);
  endfunction

  // pixel lag places behind base; nothing before the image start
  function automatic logic [PIX_W-1:0] pixel_back(int unsigned base, int unsigned lag);
    if (lag == 0 || lag > base || lag > RING_DEPTH) return '0;
    return ring[(base - lag) % RING_DEPTH];
  endfunction

  function automatic void clear_image();
    foreach (ring[i]) ring[i] = '0;
    wr_pos       = 0;
    img_finished = 1'b0;
  endfunction

  task automatic expand_token(in_t tok);
    logic [PIX_W-1:0] px [BURST_CAP];
    logic [7:0]       b;
    logic [1:0]       sel;
    int unsigned      lim, base, n, per, reps, len, k;
    out_t             beat;
    lim  = (total_cfg > PIXEL_CAP) ? PIXEL_CAP : total_cfg;
    base = wr_pos;
    if (base >= lim) begin
      img_finished = 1'b1;
      return;
    end
    if (img_finished) return;

    if (tok.op == OP_LITERAL) begin
      px[0] = tok.token_value;
      n     = 1;
    end else begin
      b = tok.token_value[7:0];
      if (!set7) begin
        sel  = b[7:6];
        per  = b[5:3] + 2;
        reps = b[2:0] + 1;
        len  = (sel == SEL_MIRROR) ? b[5:0] + 2 : b[6:0] + 1;
      end else begin
        sel  = b[6:5];
        per  = b[4:2] + 2;
        reps = b[1:0] + 1;
        len  = (sel == SEL_MIRROR) ? b[4:0] + 2 : b[5:0] + 1;
      end
      // all sources are read before the ring is touched
      case (sel)
        SEL_PATTERN: begin
          n = per * reps;
          for (k = 0; k < n; k++) px[k] = pixel_back(base, per - k % per);
        end
        SEL_MIRROR: begin
          n = len;
          for (k = 0; k < n; k++) px[k] = pixel_back(base, k + 1);
        end
        default: begin
          n = len;
          for (k = 0; k < n; k++) px[k] = pixel_back(base, 1);
        end
      endcase
    end

    if (n > lim - base) n = lim - base;
    for (k = 0; k < n; k++) ring[(base + k) % RING_DEPTH] = px[k];
    wr_pos = base + n;
    if (wr_pos >= lim) img_finished = 1'b1;

    for (k = 0; k < n; k += 2) begin
      beat.pixel_first  = px[k];
      beat.second_valid = (k + 1 < n);
      beat.pixel_second = beat.second_valid ? px[k + 1] : '0;
      beat.position     = POS_W'(base + k);
      beat.run_last     = (k + 2 >= n);
      beat.image_done   = beat.run_last && (wr_pos >= lim);
      expected_pairs.push_back(beat);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t got, want;
    if (!rst_ni) begin
      clear_image();
      set7      = 1'b0;
      total_cfg = PIXEL_TOTAL_RST;
      expected_pairs.delete();
      pending_o <= 0;
    end else begin
      // drain side first: a beat seen now never comes from a token taken now
      if (out_valid_i && !out_stall_i) begin
        got = out_i;
        if (expected_pairs.size() == 0) begin
          note_failure({"unexpected pixel beat: ", beat_text(got)});
        end else begin
          want = expected_pairs.pop_front();
          if (got.pixel_first !== want.pixel_first ||
              got.pixel_second !== want.pixel_second ||
              got.second_valid !== want.second_valid ||
              got.position !== want.position ||
              got.run_last !== want.run_last ||
              got.image_done !== want.image_done)
            note_failure({"pixel beat mismatch: expected ", beat_text(want),
                          " got ", beat_text(got)});
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_COMMAND_SET: set7 = cfg_data_i[0];
          CFG_PIXEL_TOTAL: total_cfg = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        case (in_i.op)
          OP_START:               clear_image();
          OP_LITERAL, OP_COMMAND: expand_token(in_i);
          default: ;
        endcase
      end
      pending_o <= expected_pairs.size();
    end
  end

endmodule

// File: dv/pixel_copy_command_decoder_tb.sv
`timescale 1ns / 1ps
// Testbench top of the pixel copy command decoder: clock, reset, token and
// register stimulus, receiver stalls, verdict. Uses pcc_pkg, pcc_pixel_checker.

module pixel_copy_command_decoder_tb;
  import pcc_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int QUIET_CYCLES       = 8;
  localparam int TOKENS_PER_SETTING = 22;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_t                   in_beat;
  logic                  out_valid;
  logic                  out_stall;
  out_t                  out_beat;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    pending_beats;
  int                    fail_count;
  int unsigned           send_idle_pct = 0;
  int unsigned           recv_idle_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pixel_copy_command_decoder DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_beat),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  pcc_pixel_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_i         (in_beat),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_i        (out_beat),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending_beats),
    .fail_count_o (fail_count)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic send_token(logic [1:0] op, logic [TOKEN_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= {op, value};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold off tokens until every predicted beat is out, then let dropped
  // tokens and image starts retire inside the block
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_beats != 0);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic set7, logic [TOTAL_W-1:0] total);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_COMMAND_SET;
    cfg_data  <= CFG_DATA_W'(set7);
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_PIXEL_TOTAL;
    cfg_data  <= total;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [TOTAL_W-1:0] pick_total();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) return TOTAL_W'(MAX_PIXELS_DEF + $urandom_range(MAX_PIXELS_DEF - 1));
    if (pick < 20) return TOTAL_W'(MAX_PIXELS_DEF);
    if (pick < 25) return '0;
    if (pick < 35) return TOTAL_W'($urandom_range(1, 4));
    return TOTAL_W'($urandom_range(8, 500));
  endfunction

  // images: a start, then a burst of literals and commands with some noise
  task automatic random_images(int unsigned quota, bit drain_midway);
    int unsigned sent, burst, pick;
    logic [1:0]  op;
    sent = 0;
    while (sent < quota) begin
      send_token(OP_START, TOKEN_W'($urandom));
      sent++;
      burst = $urandom_range(3, 20);
      repeat (burst) begin
        pick = $urandom_range(99);
        if (pick < 40) op = OP_LITERAL;
        else if (pick < 96) op = OP_COMMAND;
        else op = OP_UNUSED;
        send_token(op, TOKEN_W'($urandom));
        if (op != OP_UNUSED) sent++;
        if (drain_midway && sent == quota / 2) settle();
      end
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_beat   <= '0;
    out_stall <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_COMMAND_SET;
    cfg_data  <= '0;
    send_idle_pct = 8;
    recv_idle_pct = 74;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // 8-bit layout, full size
    configure(1'b0, TOTAL_W'(MAX_PIXELS_DEF));
    send_token(OP_COMMAND, 16'h0080);  // run with no pixel behind it
    send_token(OP_COMMAND, 16'h0040);  // shortest mirror, history still all zero
    send_token(OP_LITERAL, 16'h0000);
    send_token(OP_LITERAL, 16'hFFFF);
    send_token(OP_LITERAL, 16'hA5A5);
    send_token(OP_LITERAL, 16'h5A5A);
    send_token(OP_COMMAND, 16'h0000);  // pattern 2 x 1
    send_token(OP_COMMAND, 16'h003F);  // pattern 9 x 8
    send_token(OP_COMMAND, 16'h007F);  // longest mirror
    send_token(OP_COMMAND, 16'h00FF);  // longest run
    send_token(OP_COMMAND, 16'hFF85);  // upper token bits ignored
    send_token(OP_UNUSED, 16'hFFFF);
    send_token(OP_START, 16'h0000);
    send_token(OP_COMMAND, 16'h007F);  // mirror right after a start

    // 7-bit layout, tiny image: truncation, done flag, drops after done
    configure(1'b1, TOTAL_W'(5));
    send_token(OP_START, 16'hFFFF);
    send_token(OP_LITERAL, 16'h1234);
    send_token(OP_COMMAND, 16'h00FF);  // bit 7 ignored, long run cut short
    send_token(OP_LITERAL, 16'h4321);
    send_token(OP_START, 16'h0000);
    send_token(OP_COMMAND, 16'h0040);  // shortest run in this layout
    send_token(OP_COMMAND, 16'h001F);  // pattern 9 x 4, cut short
    send_token(OP_COMMAND, 16'h003F);  // longest mirror in this layout

    configure(1'b1, '0);               // empty image: all dropped
    send_token(OP_LITERAL, 16'hBEEF);
    configure(1'b0, 15'h7FFF);         // clamps to the pixel cap
    send_token(OP_START, 16'h0000);
    send_token(OP_LITERAL, 16'h0F0F);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 8;
          recv_idle_pct = 74;
        end
        1: begin
          send_idle_pct = 74;
          recv_idle_pct = 8;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int s = 0; s < 3; s++) begin
        configure((phase == 2) ? 1'($urandom_range(1)) : 1'(phase), pick_total());
        random_images(TOKENS_PER_SETTING, (phase == 0 && s == 1));
      end
    end

    settle();
    if (fail_count == 0 && pending_beats == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: pixel_copy_command_decoder.f
hdl/pcc_pkg.sv
hdl/pcc_ctrl.sv
hdl/pcc_datapath.sv
hdl/pixel_copy_command_decoder.sv
dv/pcc_pixel_checker.sv
dv/pixel_copy_command_decoder_tb.sv
